// ===== rtl/frcqp_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame rate control quantizer package
// Field widths, register indexes, reset values and codes shared by the block.
// ----------------------------------------------------------------------------
package frcqp_pkg;

  localparam int DEF_FRAC_BITS  = 8;
  localparam int DEF_BITS_WIDTH = 24;

  localparam int MODE_W     = 2;
  localparam int TBPF_W     = 24;
  localparam int LVL_W      = 27;
  localparam int SQP_W      = 6;
  localparam int PTYPE_W    = 2;
  localparam int THR_W      = 6;
  localparam int TGT_W      = TBPF_W + 3;
  localparam int QP_INT_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_RC_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_QP   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_CQP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CBR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VBR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CRF = 2'd3;

  localparam logic [PTYPE_W-1:0] PIC_INTRA = 2'd0;
  localparam logic [PTYPE_W-1:0] PIC_PRED  = 2'd1;

  localparam logic [MODE_W-1:0] RC_MODE_RST    = MODE_VBR;
  localparam logic [TBPF_W-1:0] TARGET_RST     = 24'd66666;
  localparam logic [LVL_W-1:0]  CAPACITY_RST   = 27'd4000000;
  localparam logic [LVL_W-1:0]  INIT_LEVEL_RST = 27'd2000000;
  localparam logic [SQP_W-1:0]  START_QP_RST   = 6'd23;

  localparam logic [SQP_W-1:0] QP_INT_MAX  = 6'd51;
  localparam int               DEV_INT_MAX = 64;
  localparam logic [THR_W-1:0] THR_HIGH    = 6'd50;
  localparam logic [THR_W-1:0] THR_LOW     = 6'd40;

  localparam int SM_KEEP = 19;
  localparam int SM_DIV  = 20;
  localparam int CAP_DIV = 10;

endpackage

// ===== rtl/frcqp_div.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned division producing one quotient bit per cycle through a shared
// numerator and quotient shift register.
// ----------------------------------------------------------------------------
module frcqp_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] sh_q, sh_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q, sh_q[NUM_W-1]};
    ge     = (trial >= {1'b0, den_q});
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      rem_d = '0;
      den_d = den_i;
      sh_d  = num_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      rem_d  = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      sh_d   = {sh_q[NUM_W-2:0], ge};
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

// ===== rtl/frame_rate_control_qp.sv =====
// ----------------------------------------------------------------------------
// Frame rate control quantizer
// Per coded frame, updates the virtual buffer level, the quantizer and its
// running average, and returns the quantizer for the next frame.
// ----------------------------------------------------------------------------
// One beat on the input channel describes one coded frame. The block answers
// each input beat with exactly one output beat carrying the chosen quantizer,
// the buffer level after the frame and the scene change threshold.
// The configuration channel is always ready and writes one register a beat.
// All divisions run on one serial divider of N = max(BITS_WIDTH, 27) +
// FRAC_BITS steps, one quotient bit a cycle. Each frame takes two divisions,
// and constant bitrate mode needs two more. One frame is processed at a time;
// the block is ready for the next input beat in the cycle after the result
// enters the output register.
// The output register holds a finished result while the receiver stalls, and
// the block still accepts and processes the next frame in that time; only
// the final load of the output register waits.
// Reset loads the register reset values and the matching buffer level and
// quantizer state, with no result pending.
// ----------------------------------------------------------------------------
module frame_rate_control_qp #(
  parameter int FRAC_BITS  = frcqp_pkg::DEF_FRAC_BITS,
  parameter int BITS_WIDTH = frcqp_pkg::DEF_BITS_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [frcqp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [frcqp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [frcqp_pkg::PTYPE_W-1:0]      picture_type_i,
  input  logic [BITS_WIDTH-1:0]              coded_bits_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [FRAC_BITS+frcqp_pkg::QP_INT_W-1:0] chosen_qp_o,
  output logic [frcqp_pkg::LVL_W-1:0]        level_now_o,
  output logic [frcqp_pkg::THR_W-1:0]        scene_threshold_o
);

  localparam int TGT_W = frcqp_pkg::TGT_W;
  localparam int LVL_W = frcqp_pkg::LVL_W;
  localparam int QW    = FRAC_BITS + frcqp_pkg::QP_INT_W;
  localparam int MAGW  = (BITS_WIDTH > TGT_W) ? BITS_WIDTH : TGT_W;
  localparam int NUMW  = MAGW + FRAC_BITS;
  localparam int DIFW  = MAGW + 1;
  localparam int FW    = MAGW + 1;
  localparam int CMPW  = (BITS_WIDTH > TGT_W + 2) ? BITS_WIDTH : TGT_W + 2;
  localparam int DEVW  = FRAC_BITS + 7;
  localparam int ADDW  = DEVW + 2;
  localparam int SMW   = QW + 5;
  localparam int CDW   = LVL_W - 3;

  localparam logic [QW-1:0]   QP_MAX  = QW'(frcqp_pkg::QP_INT_MAX) << FRAC_BITS;
  localparam logic [DEVW-1:0] DEV_MAX = DEVW'(frcqp_pkg::DEV_INT_MAX) << FRAC_BITS;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DEV_GO   = 4'd1;
  localparam logic [3:0] ST_DEV_WAIT = 4'd2;
  localparam logic [3:0] ST_SM_GO    = 4'd3;
  localparam logic [3:0] ST_SM_WAIT  = 4'd4;
  localparam logic [3:0] ST_CAP_GO   = 4'd5;
  localparam logic [3:0] ST_CAP_WAIT = 4'd6;
  localparam logic [3:0] ST_BUF_GO   = 4'd7;
  localparam logic [3:0] ST_BUF_WAIT = 4'd8;
  localparam logic [3:0] ST_OUT      = 4'd9;

  function automatic logic [QW-1:0] qp_step(input logic [QW-1:0] base,
                                            input logic [DEVW:0]  mag,
                                            input logic           neg);
    logic [ADDW-1:0] sum;
    sum = ADDW'(base) + ADDW'(mag);
    if (neg) begin
      if (ADDW'(mag) > ADDW'(base)) begin
        qp_step = '0;
      end else begin
        qp_step = QW'(ADDW'(base) - ADDW'(mag));
      end
    end else if (sum > ADDW'(QP_MAX)) begin
      qp_step = QP_MAX;
    end else begin
      qp_step = QW'(sum);
    end
  endfunction

  logic [3:0]                      state_q, state_d;
  logic [frcqp_pkg::MODE_W-1:0]    mode_q;
  logic [frcqp_pkg::TBPF_W-1:0]    tbpf_q;
  logic [LVL_W-1:0]                cap_q;
  logic [LVL_W-1:0]                fill_q;
  logic [QW-1:0]                   cur_q;
  logic [QW-1:0]                   sm_q;
  logic [frcqp_pkg::THR_W-1:0]     thr_q;
  logic [QW-1:0]                   qp_q;
  logic [TGT_W-1:0]                target_q, target_d;
  logic [BITS_WIDTH-1:0]           fbits_q;
  logic                            intra_q;
  logic                            neg_q;
  logic                            bneg_q;
  logic [CDW-1:0]                  capdiv_q;
  logic                            out_valid_q;
  logic [QW-1:0]                   res_qp_q;
  logic [LVL_W-1:0]                res_lvl_q;
  logic [frcqp_pkg::THR_W-1:0]     res_thr_q;

  logic [TGT_W-1:0]                t5;
  logic [DIFW-1:0]                 diff;
  logic                            diff_neg;
  logic [MAGW-1:0]                 dmag;
  logic                            lo_clip;
  logic [FW-1:0]                   fval;
  logic [LVL_W-1:0]                fill_new;
  logic [CMPW-1:0]                 t3;
  logic                            oversized;
  logic [LVL_W-1:0]                half_cap;
  logic                            bneg;
  logic [LVL_W-1:0]                bmag;
  logic [SMW-1:0]                  sm_num;
  logic [DEVW-1:0]                 sat_q;
  logic [QW-1:0]                   load_qp;
  logic [frcqp_pkg::SQP_W-1:0]     sqp_sat;
  logic                            out_free;
  logic                            in_acc;
  logic                            cfg_acc;

  logic                            div_start;
  logic [NUMW-1:0]                 div_num;
  logic [TGT_W-1:0]                div_den;
  logic                            div_done;
  logic [NUMW-1:0]                 div_quot;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    t5 = (TGT_W'(tbpf_q) << 2) + TGT_W'(tbpf_q);
    case (picture_type_i)
      frcqp_pkg::PIC_INTRA: target_d = t5;
      frcqp_pkg::PIC_PRED:  target_d = t5 >> 1;
      default:              target_d = TGT_W'(tbpf_q >> 1);
    endcase

    diff     = DIFW'(fbits_q) - DIFW'(target_q);
    diff_neg = diff[DIFW-1];
    dmag     = diff_neg ? MAGW'(DIFW'(target_q) - DIFW'(fbits_q)) : MAGW'(diff);

    lo_clip  = diff_neg && (dmag > MAGW'(fill_q));
    fval     = diff_neg ? FW'(fill_q) - FW'(dmag) : FW'(fill_q) + FW'(dmag);
    if (lo_clip) begin
      fill_new = '0;
    end else if (fval > FW'(cap_q)) begin
      fill_new = cap_q;
    end else begin
      fill_new = LVL_W'(fval);
    end

    t3        = (CMPW'(target_q) << 1) + CMPW'(target_q);
    oversized = intra_q && (CMPW'(fbits_q) > t3);

    half_cap = cap_q >> 1;
    bneg     = (fill_q < half_cap);
    bmag     = bneg ? half_cap - fill_q : fill_q - half_cap;

    sm_num = SMW'(sm_q) * SMW'(frcqp_pkg::SM_KEEP) + SMW'(cur_q);

    sat_q = (div_quot > NUMW'(DEV_MAX)) ? DEV_MAX : DEVW'(div_quot);

    sqp_sat = (cfg_data_i[frcqp_pkg::SQP_W-1:0] > frcqp_pkg::QP_INT_MAX) ?
              frcqp_pkg::QP_INT_MAX : cfg_data_i[frcqp_pkg::SQP_W-1:0];
    load_qp = QW'(sqp_sat) << FRAC_BITS;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ST_DEV_GO: begin
        div_start = 1'b1;
        div_num   = NUMW'(dmag) << FRAC_BITS;
        div_den   = target_q + TGT_W'(1);
      end
      ST_SM_GO: begin
        div_start = 1'b1;
        div_num   = NUMW'(sm_num);
        div_den   = TGT_W'(frcqp_pkg::SM_DIV);
      end
      ST_CAP_GO: begin
        div_start = 1'b1;
        div_num   = NUMW'(cap_q);
        div_den   = TGT_W'(frcqp_pkg::CAP_DIV);
      end
      ST_BUF_GO: begin
        div_start = 1'b1;
        div_num   = NUMW'(bmag) << FRAC_BITS;
        div_den   = TGT_W'(capdiv_q) + TGT_W'(1);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_acc) state_d = ST_DEV_GO;
      ST_DEV_GO:   state_d = ST_DEV_WAIT;
      ST_DEV_WAIT: if (div_done) state_d = ST_SM_GO;
      ST_SM_GO:    state_d = ST_SM_WAIT;
      ST_SM_WAIT: begin
        if (div_done) begin
          state_d = (mode_q == frcqp_pkg::MODE_CBR) ? ST_CAP_GO : ST_OUT;
        end
      end
      ST_CAP_GO:   state_d = ST_CAP_WAIT;
      ST_CAP_WAIT: if (div_done) state_d = ST_BUF_GO;
      ST_BUF_GO:   state_d = ST_BUF_WAIT;
      ST_BUF_WAIT: if (div_done) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= frcqp_pkg::RC_MODE_RST;
      tbpf_q      <= frcqp_pkg::TARGET_RST;
      cap_q       <= frcqp_pkg::CAPACITY_RST;
      fill_q      <= frcqp_pkg::INIT_LEVEL_RST;
      cur_q       <= QW'(frcqp_pkg::START_QP_RST) << FRAC_BITS;
      sm_q        <= QW'(frcqp_pkg::START_QP_RST) << FRAC_BITS;
      thr_q       <= frcqp_pkg::THR_LOW;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DEV_GO) begin
        fill_q <= fill_new;
        thr_q  <= oversized ? frcqp_pkg::THR_HIGH : frcqp_pkg::THR_LOW;
      end
      if (state_q == ST_DEV_WAIT && div_done) begin
        cur_q <= qp_step(cur_q, {sat_q, 1'b0}, neg_q);
      end
      if (state_q == ST_SM_WAIT && div_done) begin
        sm_q <= QW'(div_quot);
      end
      if (cfg_acc) begin
        case (cfg_index_i)
          frcqp_pkg::CFG_RC_MODE:    mode_q <= cfg_data_i[frcqp_pkg::MODE_W-1:0];
          frcqp_pkg::CFG_TARGET:     tbpf_q <= cfg_data_i[frcqp_pkg::TBPF_W-1:0];
          frcqp_pkg::CFG_CAPACITY:   cap_q  <= cfg_data_i[LVL_W-1:0];
          frcqp_pkg::CFG_INIT_LEVEL: fill_q <= cfg_data_i[LVL_W-1:0];
          frcqp_pkg::CFG_START_QP: begin
            cur_q <= load_qp;
            sm_q  <= load_qp;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q <= target_d;
      fbits_q  <= coded_bits_i;
      intra_q  <= (picture_type_i == frcqp_pkg::PIC_INTRA);
    end
    if (state_q == ST_DEV_GO) begin
      neg_q <= diff_neg;
    end
    if (state_q == ST_BUF_GO) begin
      bneg_q <= bneg;
    end
    if (state_q == ST_SM_WAIT && div_done) begin
      qp_q <= (mode_q == frcqp_pkg::MODE_CQP) ? cur_q : QW'(div_quot);
    end
    if (state_q == ST_CAP_WAIT && div_done) begin
      capdiv_q <= CDW'(div_quot);
    end
    if (state_q == ST_BUF_WAIT && div_done) begin
      qp_q <= qp_step(cur_q, {1'b0, sat_q}, bneg_q);
    end
    if (state_q == ST_OUT && out_free) begin
      res_qp_q  <= qp_q;
      res_lvl_q <= fill_q;
      res_thr_q <= thr_q;
    end
  end

  frcqp_div #(
    .NUM_W (NUMW),
    .DEN_W (TGT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o       = out_valid_q;
  assign chosen_qp_o       = res_qp_q;
  assign level_now_o       = res_lvl_q;
  assign scene_threshold_o = res_thr_q;

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DEV_WAIT || state_q == ST_SM_WAIT ||
                  state_q == ST_CAP_WAIT || state_q == ST_BUF_WAIT))
    else $error("divider finished outside a wait state");

  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a frame is in progress");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_valid_o) |=> out_valid_o)
    else $error("finished result not loaded into a free output register");

  a_qp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chosen_qp_o <= QP_MAX))
    else $error("chosen quantizer out of range");
`endif

endmodule
